>>> src/world_to_screen_projection_defines.svh
// ----------------------------------------------------------------------------
// world_to_screen_projection_defines
// assertion macros shared by the port checks of the projection block
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
// condition implies a property in the same cycle, outside reset
`define WSP_ASSERT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);
// condition implies a property in the next cycle, outside reset
`define WSP_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`endif

>>> src/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// shared constants and types of the projection block
// ----------------------------------------------------------------------------
package wsp_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_BITS      = 32;  // quotient bits, one divider stage each
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_NEAR   = 2'd2;
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_PROJ  = 1'b1;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction
endpackage

>>> src/wsp_clip.sv
// ----------------------------------------------------------------------------
// wsp_clip
// matrix store and clip x/y/w multiply-accumulate, two stages
// ----------------------------------------------------------------------------
module wsp_clip #(
    parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic               action,
    input  logic [3:0]         entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               out_valid,
    output logic signed [31:0] cx,
    output logic signed [31:0] cy,
    output logic signed [31:0] cw
);
    logic signed [31:0] m_reg [16];
    logic signed [63:0] p_reg [9];
    logic signed [31:0] t_reg [3];
    logic               v1_reg, v2_reg;
    logic signed [31:0] c_reg [3];
    logic signed [31:0] pos [3];
    logic [1:0]         rows [3];

    assign pos  = '{pos_x, pos_y, pos_z};
    assign rows = '{2'd0, 2'd1, 2'd3};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                m_reg[i] <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            if (in_valid && action == wsp_pkg::ACT_WRITE)
                m_reg[entry_index] <= entry_value;
            v1_reg <= in_valid && action == wsp_pkg::ACT_PROJ;
            v2_reg <= v1_reg;
        end
    end

    // stage 1: nine products, stage 2: floor shift and sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                    p_reg[r*3+k] <= 64'(pos[k]) * 64'(m_reg[{rows[r], 2'(k)}]);
                t_reg[r] <= m_reg[{rows[r], 2'd3}];
            end
            for (int r = 0; r < 3; r++)
                c_reg[r] <= wsp_pkg::sat32(64'(t_reg[r])
                    + (p_reg[r*3] >>> FRAC_BITS) + (p_reg[r*3+1] >>> FRAC_BITS)
                    + (p_reg[r*3+2] >>> FRAC_BITS));
        end
    end

    assign out_valid = v2_reg;
    assign cx = c_reg[0];
    assign cy = c_reg[1];
    assign cw = c_reg[2];
endmodule

>>> src/wsp_div.sv
// ----------------------------------------------------------------------------
// wsp_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module wsp_div #(
    parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] num,
    input  logic [30:0]        den,
    output logic signed [31:0] quo
);
    // |num| << FRAC_BITS needs 32+FRAC_BITS bits; the bits above the low 32
    // seed the remainder and decide overflow, the low 32 are brought down one per stage
    localparam int NW = 32 + FRAC_BITS;
    localparam int QB = wsp_pkg::DIV_BITS;
    logic [31:0]   mag;
    logic [NW-1:0] nfull;
    logic [31:0]   n_reg [QB+1];
    logic [30:0]   d_reg [QB+1];
    logic [31:0]   r_reg [QB+1];
    logic          s_reg [QB+1];
    logic          o_reg [QB+1];
    logic [31:0]   q_reg [QB+1];
    logic [32:0]   t [QB];
    logic          ge [QB];

    always_comb
    begin
        mag   = num[31] ? 32'(-num) : 32'(num);
        nfull = {mag, FRAC_BITS'(0)};
    end

    // trial subtract of each stage
    always_comb
    begin
        for (int i = 0; i < QB; i++)
        begin
            t[i]  = {r_reg[i], n_reg[i][31]};
            ge[i] = t[i] >= {2'b00, d_reg[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= nfull[31:0];
            d_reg[0] <= den;
            r_reg[0] <= 32'(nfull[NW-1:32]);
            // quotient reaches 2^32 when the high bits alone cover den
            o_reg[0] <= 32'(nfull[NW-1:32]) >= {1'b0, den};
            s_reg[0] <= num[31];
            q_reg[0] <= '0;
            for (int i = 0; i < QB; i++)
            begin
                n_reg[i+1] <= n_reg[i] << 1;
                d_reg[i+1] <= d_reg[i];
                s_reg[i+1] <= s_reg[i];
                o_reg[i+1] <= o_reg[i];
                r_reg[i+1] <= ge[i] ? 32'(t[i] - {2'b00, d_reg[i]}) : t[i][31:0];
                q_reg[i+1] <= {q_reg[i][30:0], ge[i]};
            end
        end
    end

    always_comb
    begin
        if (s_reg[QB])
            quo = (o_reg[QB] || q_reg[QB][31]) ? 32'sh80000000 : -$signed(q_reg[QB]);
        else
            quo = (o_reg[QB] || q_reg[QB][31]) ? 32'sh7fffffff : $signed(q_reg[QB]);
    end
endmodule

>>> src/world_to_screen_projection.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection
// vertex projection: 4x4 clip transform, perspective divide, viewport map
// ----------------------------------------------------------------------------
//  channel | valid     | ready     | word
//  in      | in_valid  | in_ready  | action, entry, pos
//  out     | out_valid | out_ready | screen_x, screen_y, behind
//  cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// one word per cycle in and out while the receiver keeps up
// a point shows on out_valid after two mac stages, the divider input
// register, 32 divider stages and the output register
// a matrix write gives no word and is seen by a point accepted on the next edge
// the whole pipeline advances together and halts while the output holds a word
// that is not taken; in_ready drops with it. reset clears matrix and valids
module world_to_screen_projection #(
    parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [3:0]         entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    output logic               behind,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    // divider depth: input register plus one stage per quotient bit
    localparam int DL = wsp_pkg::DIV_BITS + 1;
    logic [13:0] w_reg, h_reg;
    logic [20:0] near_reg;
    logic en;
    logic cv;
    logic signed [31:0] cx, cy, cw;
    logic vis;
    logic [DL-1:0] v_reg, b_reg;
    logic signed [31:0] nx, ny;
    logic signed [31:0] sx_reg, sy_reg;
    logic ov_reg, ob_reg;

    // pipeline moves whenever the output slot is free or being drained
    assign en        = !ov_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= 14'd1920;
            h_reg <= 14'd1080;
            near_reg <= 21'd6554;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                wsp_pkg::REG_WIDTH:  w_reg <= cfg_data[13:0];
                wsp_pkg::REG_HEIGHT: h_reg <= cfg_data[13:0];
                wsp_pkg::REG_NEAR:   near_reg <= cfg_data[20:0];
                default: ;
            endcase
        end
    end

    wsp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
        .clk, .rst_n, .en, .in_valid(in_valid && in_ready), .action, .entry_index,
        .entry_value, .pos_x, .pos_y, .pos_z, .out_valid(cv), .cx, .cy, .cw
    );

    // behind when w below near limit or zero
    assign vis = !(cw < $signed({11'd0, near_reg}) || cw == 0);

    wsp_div #(.FRAC_BITS(FRAC_BITS)) u_dx (.clk, .en, .num(cx), .den(cw[30:0]), .quo(nx));
    wsp_div #(.FRAC_BITS(FRAC_BITS)) u_dy (.clk, .en, .num(cy), .den(cw[30:0]), .quo(ny));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DL-2:0], cv};
            ov_reg <= v_reg[DL-1];
        end
    end

    localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;
    logic signed [33:0] ax, ay;
    logic signed [48:0] px, py;
    always_comb
    begin
        ax = ONE + 34'(nx);
        ay = ONE - 34'(ny);
        px = $signed({1'b0, w_reg}) * ax;
        py = $signed({1'b0, h_reg}) * ay;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg  <= {b_reg[DL-2:0], !vis};
            ob_reg <= b_reg[DL-1];
            if (b_reg[DL-1])
            begin
                sx_reg <= -(32'sd1 <<< FRAC_BITS);
                sy_reg <= -(32'sd1 <<< FRAC_BITS);
            end
            else
            begin
                sx_reg <= wsp_pkg::sat32(64'(px >>> 1));
                sy_reg <= wsp_pkg::sat32(64'(py >>> 1));
            end
        end
    end

    assign out_valid = ov_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;
    assign behind    = ob_reg;
endmodule

>>> src/wsp_checker.sv
// ----------------------------------------------------------------------------
// wsp_checker
// port level checks of the projection block
// ----------------------------------------------------------------------------
`include "world_to_screen_projection_defines.svh"
module wsp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] screen_x,
    input logic               behind
);
    `WSP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(screen_x), "out lost")
    `WSP_ASSERT(a_ready, out_valid && !out_ready, !in_ready, "ready while stalled")
    `WSP_ASSERT(a_behind, out_valid && behind, screen_x < 0, "behind value")
endmodule

bind world_to_screen_projection wsp_checker u_chk (
    .clk, .rst_n, .in_ready, .out_valid, .out_ready, .screen_x, .behind
);

>>> sim/world_to_screen_projection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection_checker
// watches the cfg, in and out channels, projects each accepted point with
// its own copy of the matrix and registers, and compares the screen words
// ----------------------------------------------------------------------------
module world_to_screen_projection_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               action,
    input  logic [3:0]         entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] screen_x,
    input  logic signed [31:0] screen_y,
    input  logic               behind,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 errors,
    output int                 pending
);
    localparam int FB = wsp_pkg::FRAC_BITS_DEF;
    localparam longint ONE = 64'sd1 <<< FB;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               behind;
    } screen_word_t;

    longint       view_coef [16];
    longint       width_px;
    longint       height_px;
    longint       near_w;
    screen_word_t screen_q [$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // one row of the clip transform, each product floored after the shift
    function automatic longint clip_row(int row, longint px, longint py, longint pz);
        longint acc;
        acc = view_coef[row * 4 + 3];
        acc += (px * view_coef[row * 4]) >>> FB;
        acc += (py * view_coef[row * 4 + 1]) >>> FB;
        acc += (pz * view_coef[row * 4 + 2]) >>> FB;
        return clamp32(acc);
    endfunction

    function automatic screen_word_t project_point(logic signed [31:0] px,
                                                   logic signed [31:0] py,
                                                   logic signed [31:0] pz);
        screen_word_t r;
        longint cx, cy, cw, nx, ny;
        cx = clip_row(0, px, py, pz);
        cy = clip_row(1, px, py, pz);
        cw = clip_row(3, px, py, pz);
        if (cw < near_w || cw == 0) begin
            r.sx = 32'(-ONE);
            r.sy = 32'(-ONE);
            r.behind = 1'b1;
        end
        else begin
            nx = clamp32((cx * ONE) / cw);
            ny = clamp32((cy * ONE) / cw);
            r.sx = 32'(clamp32((width_px * (ONE + nx)) >>> 1));
            r.sy = 32'(clamp32((height_px * (ONE - ny)) >>> 1));
            r.behind = 1'b0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        screen_word_t want;
        if (!rst_n)
        begin
            foreach (view_coef[i])
                view_coef[i] = 0;
            width_px  = 1920;
            height_px = 1080;
            near_w    = 6554;
            screen_q.delete();
            errors    = 0;
            pending   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    wsp_pkg::REG_WIDTH:  width_px  = longint'(cfg_data[13:0]);
                    wsp_pkg::REG_HEIGHT: height_px = longint'(cfg_data[13:0]);
                    wsp_pkg::REG_NEAR:   near_w    = longint'(cfg_data[20:0]);
                    default:    ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (screen_q.size() == 0)
                begin
                    $display("%0t: screen word with nothing expected", $time);
                    errors++;
                end
                else
                begin
                    want = screen_q.pop_front();
                    if (screen_x !== want.sx)
                    begin
                        $display("%0t: screen_x expected %h actual %h", $time, want.sx, screen_x);
                        errors++;
                    end
                    if (screen_y !== want.sy)
                    begin
                        $display("%0t: screen_y expected %h actual %h", $time, want.sy, screen_y);
                        errors++;
                    end
                    if (behind !== want.behind)
                    begin
                        $display("%0t: behind expected %b actual %b", $time, want.behind, behind);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (action == wsp_pkg::ACT_WRITE)
                    view_coef[entry_index] = longint'(entry_value);
                else
                    screen_q = {screen_q, project_point(pos_x, pos_y, pos_z)};
            end
            pending = screen_q.size();
        end
    end
endmodule

>>> sim/world_to_screen_projection_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection_test
// drives matrix writes and points through the projection block under several
// viewport and near settings, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module world_to_screen_projection_test;
    localparam logic [1:0] REG_SPARE = 2'd3;   // unmapped register index
    localparam int ONE_Q = 65536;
    localparam int SETTLE = 300;               // extra wait once nothing is pending
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_WORDS = 105;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               action;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               behind;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    int errors;
    int pending;
    int idle_cycles;
    int point_count;
    int coef_count;
    int setting_count;
    bit calm;          // no idling on either side
    bit long_hold;     // ask the receiver for one long stall

    world_to_screen_projection dut (.*);

    world_to_screen_projection_checker checker_i (.*);

    always #5 clk = ~clk;

    // watchdog: cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                long_hold = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // one word on the input channel; valid stays up into the next word unless a random gap drops it
    task automatic send_word(logic act, logic [3:0] idx, logic [31:0] val,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        action      <= act;
        entry_index <= idx;
        entry_value <= val;
        pos_x       <= px;
        pos_y       <= py;
        pos_z       <= pz;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (act == wsp_pkg::ACT_WRITE)
            coef_count++;
        else
            point_count++;
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic write_coef(logic [3:0] idx, logic [31:0] val);
        send_word(wsp_pkg::ACT_WRITE, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        send_word(wsp_pkg::ACT_PROJ, 4'($urandom), $urandom, px, py, pz);
    endtask

    // wait for every expected word, then let any trailing writes settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // viewport and near limit; junk goes into the bits above each register
    task automatic set_viewport(int w, int h, int near);
        write_reg(wsp_pkg::REG_WIDTH,  w | ($urandom << 14));
        write_reg(wsp_pkg::REG_HEIGHT, h | ($urandom << 14));
        write_reg(wsp_pkg::REG_NEAR,   near | ($urandom << 21));
        setting_count++;
    endtask

    // perspective-like matrix with random scale and offsets; w follows z
    task automatic load_view_matrix();
        for (int i = 0; i < 16; i++)
        begin
            case (i)
                0, 5:    write_coef(4'(i), $urandom_range(ONE_Q / 4, 3 * ONE_Q));
                3, 7:    write_coef(4'(i), $urandom_range(0, 4 * ONE_Q) - 2 * ONE_Q);
                14:      write_coef(4'(i), $urandom_range(ONE_Q / 2, 2 * ONE_Q));
                15:      write_coef(4'(i), $urandom_range(0, ONE_Q / 2) - ONE_Q / 4);
                1, 4:    write_coef(4'(i), $urandom_range(0, ONE_Q / 4) - ONE_Q / 8);
                12, 13:  write_coef(4'(i), $urandom_range(0, ONE_Q / 16) - ONE_Q / 32);
                default: write_coef(4'(i), $urandom);
            endcase
        end
    endtask

    // mostly plausible scene points, some noise and stray coefficient writes
    task automatic random_phase(int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                write_coef(4'($urandom), $urandom);
            else if (pick < 20)
                send_point($urandom, $urandom, $urandom);
            else if (pick < 26)
                send_point($urandom, $urandom, $urandom_range(0, 2) - 1);
            else
                send_point($urandom_range(0, 40 * ONE_Q) - 20 * ONE_Q,
                           $urandom_range(0, 40 * ONE_Q) - 20 * ONE_Q,
                           $urandom_range(0, 64 * ONE_Q) - 2 * ONE_Q);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = wsp_pkg::ACT_WRITE;
        entry_index = '0;
        entry_value = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        cfg_valid = 1'b0;
        cfg_index = wsp_pkg::REG_WIDTH;
        cfg_data = '0;
        idle_cycles = 0;
        point_count = 0;
        coef_count = 0;
        setting_count = 0;
        calm = 1'b0;
        long_hold = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: cleared matrix gives zero w, so the point is behind
        send_point(ONE_Q, ONE_Q, ONE_Q);
        // identity in x and y, w taken from z
        write_coef(4'd0, ONE_Q);
        write_coef(4'd5, ONE_Q);
        write_coef(4'd14, ONE_Q);
        send_point(0, 0, ONE_Q);                          // screen center
        send_point(ONE_Q, -ONE_Q, ONE_Q);                 // corner at ndc (1, -1)
        send_point(0, 0, 0);                              // zero w
        send_point(0, 0, -ONE_Q);                         // negative w
        send_point(0, 0, 6553);                           // just under near
        send_point(0, 0, 6554);                           // exactly at near
        send_point(32'h7fffffff, 32'h80000000, 6554);     // ndc saturates
        send_point(32'h80000000, 32'h7fffffff, 32'h7fffffff);
        write_coef(4'd3, 32'h7fffffff);                   // translation extremes
        write_coef(4'd7, 32'h80000000);
        send_point(ONE_Q, ONE_Q, ONE_Q);
        write_coef(4'd12, 32'h7fffffff);                  // w overflow clamps
        send_point(32'h7fffffff, 0, 32'h7fffffff);
        write_coef(4'd15, 32'h80000000);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        write_coef(4'd15, 0);
        write_coef(4'd12, 0);
        send_point(-3 * ONE_Q, 5 * ONE_Q, 2 * ONE_Q);
        drain();

        // register extremes: one pixel wide, near at zero so zero w is tested
        set_viewport(1, 1, 0);
        write_reg(REG_SPARE, $urandom);
        send_point(0, 0, 0);
        send_point(ONE_Q, ONE_Q, 1);
        send_point(-ONE_Q, -ONE_Q, ONE_Q);
        load_view_matrix();
        random_phase(PHASE_WORDS);
        drain();

        // long receiver stall while points keep coming
        set_viewport(8192, 8192, 1048576);
        load_view_matrix();
        long_hold = 1'b1;
        random_phase(PHASE_WORDS);
        drain();

        set_viewport(16383, 16383, 2097151);
        load_view_matrix();
        random_phase(PHASE_WORDS);
        drain();

        set_viewport(0, 0, $urandom_range(0, 2097151));
        load_view_matrix();
        random_phase(PHASE_WORDS / 2);
        drain();

        // last stretch with no idling on either side
        set_viewport($urandom_range(1, 8192), $urandom_range(1, 8192),
                     $urandom_range(0, 65536));
        load_view_matrix();
        calm = 1'b1;
        random_phase(PHASE_WORDS);
        drain();

        $display("covered %0d points and %0d coefficient writes", point_count, coef_count);
        $display("across %0d viewport and near-limit settings", setting_count + 1);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
